### rtl/dssar_pkg.sv
// Shared types, constants and the sine table for the DDS symbol sequencer.
// Used by every other file of the block but dssar_ram; depends on nothing.

package dssar_pkg;

  // Sizing of the block.
  localparam int unsigned SEQUENCE_DEPTH = 16;
  localparam int unsigned BLOCK_LEN      = 256;
  localparam int unsigned TABLE_ENTRIES  = 1024;
  // The ramp step is a shift, so RAMP_LEN is kept at a power of two.
  localparam int unsigned RAMP_LEN       = 32;

  // Field widths of the request and result.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned AMP_W      = 12;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned STEPS_W    = 5;

  // Derived internal widths.
  localparam int unsigned SYM_W      = $clog2(SEQUENCE_DEPTH);
  localparam int unsigned ROM_AW     = $clog2(TABLE_ENTRIES);
  localparam int unsigned POS_W      = $clog2(BLOCK_LEN);
  localparam int unsigned RCNT_W     = $clog2(RAMP_LEN + 1);
  localparam int unsigned RAMP_SHIFT = $clog2(RAMP_LEN);
  localparam int unsigned DELTA_W    = AMP_W + 1;
  localparam int unsigned PROD_W     = SAMPLE_W + AMP_W;

  // Mid-scale of the DAC code and the largest amplitude.
  localparam logic [SAMPLE_W:0]  SAMPLE_MID = (SAMPLE_W + 1)'(2048);
  localparam logic [AMP_W-1:0]   AMP_MAX    = '1;

  // Configuration port.
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_STEPS_IN_USE = '0;
  localparam logic [STEPS_W-1:0]   STEPS_RESET      = STEPS_W'(1);

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_STOP  = 2'd3
  } op_e;

  // One request item.
  typedef struct packed {
    op_e                  op;
    logic [IDX_W-1:0]     entry_index;
    logic [PHASE_W-1:0]   phase_step;
    logic [AMP_W-1:0]     amplitude_code;
    logic [DUR_W-1:0]     duration_blocks;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample;
    logic                 sample_valid;
    logic                 running;
    logic [IDX_W-1:0]     symbol_now;
    logic                 finished;
  } rsp_t;

  // One entry of the symbol table.
  typedef struct packed {
    logic [PHASE_W-1:0]   phase_step;
    logic [AMP_W-1:0]     amplitude;
    logic [DUR_W-1:0]     duration;
  } sym_entry_t;

  localparam int unsigned ENTRY_W = $bits(sym_entry_t);

  // Symbol table access from the engine.
  typedef struct packed {
    logic                 wr_en;
    logic [SYM_W-1:0]     wr_addr;
    sym_entry_t           wr_data;
    logic                 rd_en;
    logic [SYM_W-1:0]     rd_addr_a;
    logic [SYM_W-1:0]     rd_addr_b;
  } mem_req_t;

  // Sine table generation, evaluated at elaboration only.
  typedef logic [SAMPLE_W-1:0] wave_tab_t [TABLE_ENTRIES];

  localparam longint unsigned Q30_ONE      = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam longint unsigned HALF_TURN    = 64'd2147483648;
  localparam longint unsigned QUARTER_TURN = 64'd1073741824;
  localparam longint unsigned SINE_AMP     = 64'd2047;
  localparam longint unsigned SERIES_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // Sine of a quarter-turn fraction (turns in Q32, up to a quarter), result in Q30.
  function automatic longint unsigned quarter_sine(longint unsigned t);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x    = (t * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / SERIES_DIV[n-1];
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum > Q30_ONE) ? Q30_ONE : sum;
  endfunction

  // Full-wave table about 2047; the negative half rounds its magnitude up.
  function automatic wave_tab_t build_wave_tab();
    wave_tab_t       tab;
    longint unsigned t;
    longint unsigned m;
    longint unsigned mag;
    logic            neg;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      t   = (64'(k) << 32) / TABLE_ENTRIES;
      neg = (t >= HALF_TURN);
      if (neg) begin
        t = t - HALF_TURN;
      end
      if (t > QUARTER_TURN) begin
        t = HALF_TURN - t;
      end
      m = SINE_AMP * quarter_sine(t);
      if (neg) begin
        mag    = (m + Q30_ONE - 64'd1) >> 30;
        tab[k] = SAMPLE_W'(SINE_AMP - mag);
      end else begin
        mag    = m >> 30;
        tab[k] = SAMPLE_W'(SINE_AMP + mag);
      end
    end
    return tab;
  endfunction

  localparam wave_tab_t WAVE_TAB = build_wave_tab();

endpackage

### rtl/dssar_req_if.sv
// Request channel of the DDS symbol sequencer: valid/ready plus one request item.
// Depends on dssar_pkg for the payload type.

interface dssar_req_if
  import dssar_pkg::*;
();

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### rtl/dssar_rsp_if.sv
// Result channel of the DDS symbol sequencer: valid/ready plus one result item.
// Depends on dssar_pkg for the payload type.

interface dssar_rsp_if
  import dssar_pkg::*;
();

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### rtl/dssar_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// Stand-alone; no package needed.

module dssar_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports hold their data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### rtl/dssar_sine_rom.sv
// Sine ROM with registered read, contents from the table in dssar_pkg.
// Depends on dssar_pkg.

module dssar_sine_rom
  import dssar_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [ROM_AW-1:0]   addr_i,
  output logic [SAMPLE_W-1:0] data_o
);

  logic [SAMPLE_W-1:0] data_q;

  // The read data is held between lookups.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= WAVE_TAB[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

### rtl/dssar_apb_regs.sv
// APB-style configuration register file: holds steps_in_use.
// Depends on dssar_pkg.

module dssar_apb_regs
  import dssar_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output logic [STEPS_W-1:0]  steps_in_use_o
);

  logic [STEPS_W-1:0]   steps_q;
  logic [STEPS_W-1:0]   steps_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_fire;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  // Register write decode.
  always_comb begin
    steps_d = steps_q;
    if (wr_fire && (reg_idx == REG_STEPS_IN_USE)) begin
      steps_d = pwdata[STEPS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEPS_RESET;
    end else begin
      steps_q <= steps_d;
    end
  end

  // Read-back.
  assign prdata = (reg_idx == REG_STEPS_IN_USE) ?
                  {{(APB_DW - STEPS_W){1'b0}}, steps_q} : '0;

  assign steps_in_use_o = steps_q;

endmodule

### rtl/dssar_engine.sv
// Sequencer engine: fetch stage for the symbol table and sine ROM, execute stage
// holding the synthesiser state, and the result register. Depends on dssar_pkg
// and the two channel interfaces.

module dssar_engine
  import dssar_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  dssar_req_if.sink           in_req,
  dssar_rsp_if.source         out_rsp,
  input  logic [STEPS_W-1:0]  steps_in_use_i,
  output mem_req_t            mem_req_o,
  input  sym_entry_t          entry_a_i,
  input  sym_entry_t          entry_b_i,
  output logic                rom_en_o,
  output logic [ROM_AW-1:0]   rom_addr_o,
  input  logic [SAMPLE_W-1:0] rom_data_i
);

  // Handshake and pipeline control.
  logic accept;
  logic fire;
  logic p_valid_q;
  op_e  p_op_q;
  logic out_valid_q;
  rsp_t out_data_q;

  // Synthesiser state.
  logic [PHASE_W-1:0] phase_q,    phase_d;
  logic [PHASE_W-1:0] inc_q,      inc_d;
  logic [AMP_W-1:0]   amp_q,      amp_d;
  logic [AMP_W-1:0]   tgt_q,      tgt_d;
  logic [DELTA_W-1:0] delta_q,    delta_d;
  logic [RCNT_W-1:0]  rcnt_q,     rcnt_d;
  logic               ramping_q,  ramping_d;
  logic [SYM_W-1:0]   sym_q,      sym_d;
  logic [DUR_W-1:0]   blocks_q,   blocks_d;
  logic [POS_W-1:0]   pos_q,      pos_d;
  logic               run_q,      run_d;

  // Execute helpers.
  logic [SYM_W-1:0]   last_sym;
  logic [SYM_W-1:0]   sym_rd;
  sym_entry_t         load_entry;
  logic [DELTA_W-1:0] diff;
  logic [DELTA_W-1:0] diff_mag;
  logic [DELTA_W-1:0] delta_mag;
  logic [DELTA_W-1:0] delta_new;
  logic               load_en;
  logic               ended;
  logic               tick_en;
  logic [AMP_W+1:0]   amp_sum;
  logic [PROD_W-1:0]  product;
  logic [SAMPLE_W:0]  sample_sum;
  rsp_t               rsp_d;

  // An item moves on from the fetch register when the result register frees up.
  assign fire          = p_valid_q && (!out_valid_q || out_rsp.ready);
  assign in_req.ready  = !p_valid_q || fire;
  assign accept        = in_req.valid && in_req.ready;

  // Index of the last symbol played; zero counts as one, too many as the table size.
  always_comb begin
    if (steps_in_use_i == '0) begin
      last_sym = '0;
    end else if (32'(steps_in_use_i) > SEQUENCE_DEPTH) begin
      last_sym = SYM_W'(SEQUENCE_DEPTH - 1);
    end else begin
      last_sym = SYM_W'(steps_in_use_i - STEPS_W'(1));
    end
  end

  // Fetch addresses follow the state left by the item executing this cycle.
  assign sym_rd = (sym_d >= last_sym) ? last_sym : sym_d;

  always_comb begin
    mem_req_o.wr_en           = accept && (in_req.data.op == OP_LOAD);
    mem_req_o.wr_addr         = SYM_W'(in_req.data.entry_index);
    mem_req_o.wr_data.phase_step = in_req.data.phase_step;
    mem_req_o.wr_data.amplitude  = in_req.data.amplitude_code;
    mem_req_o.wr_data.duration   = in_req.data.duration_blocks;
    mem_req_o.rd_en           = accept && (in_req.data.op != OP_LOAD);
    mem_req_o.rd_addr_a       = (in_req.data.op == OP_START) ? '0 : sym_rd;
    mem_req_o.rd_addr_b       = sym_rd + SYM_W'(1);
  end

  assign rom_en_o   = accept;
  assign rom_addr_o = phase_d[PHASE_W-1 -: ROM_AW];

  // Ramp step for a newly loaded symbol, truncated toward zero.
  assign load_entry = (p_op_q == OP_START) ? entry_a_i : entry_b_i;
  assign diff       = {1'b0, load_entry.amplitude} - {1'b0, amp_q};
  assign diff_mag   = diff[DELTA_W-1] ? (-diff) : diff;
  assign delta_mag  = diff_mag >> RAMP_SHIFT;
  assign delta_new  = diff[DELTA_W-1] ? (-delta_mag) : delta_mag;

  // Execute stage: next state and the result of the item in the fetch register.
  always_comb begin
    phase_d    = phase_q;
    inc_d      = inc_q;
    amp_d      = amp_q;
    tgt_d      = tgt_q;
    delta_d    = delta_q;
    rcnt_d     = rcnt_q;
    ramping_d  = ramping_q;
    sym_d      = sym_q;
    blocks_d   = blocks_q;
    pos_d      = pos_q;
    run_d      = run_q;
    load_en    = 1'b0;
    ended      = 1'b0;
    tick_en    = 1'b0;
    amp_sum    = '0;
    product    = '0;
    sample_sum = '0;
    rsp_d      = '0;

    if (fire) begin
      unique case (p_op_q)
        OP_LOAD: begin
        end
        OP_START: begin
          run_d   = 1'b1;
          sym_d   = '0;
          pos_d   = '0;
          load_en = 1'b1;
        end
        OP_STOP: begin
          run_d = 1'b0;
        end
        OP_TICK: begin
          if (run_q) begin
            // Symbol boundaries are only checked at the start of a block.
            if (pos_q == '0) begin
              if (sym_q >= last_sym) begin
                sym_d = last_sym;
                ended = (blocks_q >= entry_a_i.duration);
              end else if (blocks_q >= entry_a_i.duration) begin
                sym_d   = sym_q + SYM_W'(1);
                load_en = 1'b1;
              end
            end
            tick_en = !ended;
          end
        end
        default: begin
        end
      endcase

      if (load_en) begin
        inc_d     = load_entry.phase_step;
        tgt_d     = load_entry.amplitude;
        delta_d   = delta_new;
        rcnt_d    = '0;
        ramping_d = 1'b1;
        blocks_d  = '0;
      end

      if (ended) begin
        run_d          = 1'b0;
        rsp_d.finished = 1'b1;
      end

      if (tick_en) begin
        // Amplitude ramp over the first positions of the block, then snap.
        if (ramping_d && (32'(pos_q) < RAMP_LEN)) begin
          amp_sum = {2'b00, amp_q} + {delta_d[DELTA_W-1], delta_d};
          if (amp_sum[AMP_W+1]) begin
            amp_d = '0;
          end else if (amp_sum[AMP_W]) begin
            amp_d = AMP_MAX;
          end else begin
            amp_d = amp_sum[AMP_W-1:0];
          end
          rcnt_d = rcnt_d + RCNT_W'(1);
          if (32'(rcnt_d) >= RAMP_LEN) begin
            ramping_d = 1'b0;
            amp_d     = tgt_d;
          end
        end

        // Scale the table value about mid-scale.
        product    = PROD_W'(rom_data_i) * PROD_W'(amp_d);
        sample_sum = SAMPLE_MID - {2'b00, amp_d[AMP_W-1:1]} +
                     {1'b0, product[PROD_W-1 -: SAMPLE_W]};
        rsp_d.sample       = sample_sum[SAMPLE_W-1:0];
        rsp_d.sample_valid = 1'b1;

        // Advance phase and block position.
        phase_d = phase_q + inc_d;
        if (32'(pos_q) == (BLOCK_LEN - 1)) begin
          pos_d = '0;
          if (blocks_d != '1) begin
            blocks_d = blocks_d + DUR_W'(1);
          end
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end

      rsp_d.running    = run_d;
      rsp_d.symbol_now = IDX_W'(sym_d);
    end
  end

  // Control and synthesiser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      inc_q       <= '0;
      amp_q       <= '0;
      tgt_q       <= '0;
      delta_q     <= '0;
      rcnt_q      <= '0;
      ramping_q   <= 1'b0;
      sym_q       <= '0;
      blocks_q    <= '0;
      pos_q       <= '0;
      run_q       <= 1'b0;
    end else begin
      if (accept) begin
        p_valid_q <= 1'b1;
      end else if (fire) begin
        p_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_q <= 1'b0;
      end
      phase_q   <= phase_d;
      inc_q     <= inc_d;
      amp_q     <= amp_d;
      tgt_q     <= tgt_d;
      delta_q   <= delta_d;
      rcnt_q    <= rcnt_d;
      ramping_q <= ramping_d;
      sym_q     <= sym_d;
      blocks_q  <= blocks_d;
      pos_q     <= pos_d;
      run_q     <= run_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_op_q <= in_req.data.op;
    end
    if (fire) begin
      out_data_q <= rsp_d;
    end
  end

  assign out_rsp.valid = out_valid_q;
  assign out_rsp.data  = out_data_q;

  // The ramp counter never passes its end while a ramp is active.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramping_q |-> (32'(rcnt_q) < RAMP_LEN))
    else $error("ramp counter overran while ramping");

  // A finished sequence leaves the block stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && rsp_d.finished) |=> !run_q)
    else $error("sequence end did not stop the block");

  // An accepted request always lands in the fetch register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> p_valid_q)
    else $error("accepted request lost before execute");

  // Every executed request leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("executed request produced no result");

endmodule

### rtl/dds_symbol_sequencer_amplitude_ramp.sv
// Top level of the DDS symbol sequencer with amplitude ramp.
// Depends on dssar_pkg, the channel interfaces, dssar_ram, dssar_sine_rom,
// dssar_apb_regs and dssar_engine.

// The block takes one request per clock while results are taken and gives one
// result per request, in order. A request is accepted into a fetch register while
// the symbol table (a 16-entry two-port RAM) and the 1024-entry sine ROM are
// read; once the output register can take its result, it executes against the
// phase accumulator and ramp state and its result is placed in the output
// register, and back-to-back requests sustain one per clock as long as results
// are taken. The fetch addresses come from the state the executing request
// leaves behind, which is what lets a request follow in the next cycle.
// Symbol entries must be loaded before a start or tick reads them; after reset
// the table contents are undefined and there is no clearing pass.
// steps_in_use is to be written by the user through the APB-style port only while
// no request is in flight; the block itself does not enforce this.

module dds_symbol_sequencer_amplitude_ramp
  import dssar_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  dssar_req_if.sink          in_req,
  dssar_rsp_if.source        out_rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic [STEPS_W-1:0]  steps_in_use;
  mem_req_t            mem_req;
  sym_entry_t          entry_a;
  sym_entry_t          entry_b;
  logic                rom_en;
  logic [ROM_AW-1:0]   rom_addr;
  logic [SAMPLE_W-1:0] rom_data;

  // Configuration registers.
  dssar_apb_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .steps_in_use_o (steps_in_use)
  );

  // Symbol table.
  dssar_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SEQUENCE_DEPTH)
  ) u_sym_ram (
    .clk_i     (clk_i),
    .we_i      (mem_req.wr_en),
    .waddr_i   (mem_req.wr_addr),
    .wdata_i   (mem_req.wr_data),
    .re_i      (mem_req.rd_en),
    .raddr_a_i (mem_req.rd_addr_a),
    .raddr_b_i (mem_req.rd_addr_b),
    .rdata_a_o (entry_a),
    .rdata_b_o (entry_b)
  );

  // Sine lookup.
  dssar_sine_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (rom_en),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // Sequencer engine.
  dssar_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_req         (in_req),
    .out_rsp        (out_rsp),
    .steps_in_use_i (steps_in_use),
    .mem_req_o      (mem_req),
    .entry_a_i      (entry_a),
    .entry_b_i      (entry_b),
    .rom_en_o       (rom_en),
    .rom_addr_o     (rom_addr),
    .rom_data_i     (rom_data)
  );

endmodule
